[rtl/ptc_pkg.sv]
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, constants and the divider step for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam logic [19:0] SKIP_MARK  = 20'h80000;
  localparam int          DIV_STAGES = 64;
  localparam logic [24:0] PRESS_MAX  = 25'h1FFFFFF;
  localparam logic [63:0] P_OFFSET   = 64'h0000_8000_0000_0000;
  localparam logic [24:0] FINE_BIAS  = 25'd128000;
  localparam logic [63:0] P_SCALE    = 64'd3125;
  localparam logic [20:0] P_FULL     = 21'h100000;

  // Configuration register indexes
  localparam logic [1:0] REG_TEMP_TRIM  = 2'd0;
  localparam logic [1:0] REG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] REG_PRESS_MID  = 2'd2;
  localparam logic [1:0] REG_PRESS_HIGH = 2'd3;

  // Decoded trim words
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } trim_t;

  // Divider operands and side data leaving the front end
  typedef struct packed {
    logic [63:0] un;
    logic [30:0] ud;
    logic        neg;
    logic        zero;
    logic        skip;
    logic [15:0] temp;
  } front_t;

  // One divider stage
  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] dvd;
    logic [30:0] den;
    logic        neg;
    logic        zero;
    logic        skip;
    logic [15:0] temp;
  } div_t;

  // One result
  typedef struct packed {
    logic [15:0] temperature_centi;
    logic [24:0] pressure_q8;
    logic        sample_ok;
    logic        pressure_ok;
  } result_t;

  // Retire one quotient bit: shift in a dividend bit, compare, subtract
  function automatic div_t div_step(div_t s);
    div_t        r;
    logic [31:0] trial;
    r     = s;
    trial = {s.rem, s.dvd[63]};
    if (trial >= {1'b0, s.den}) begin
      r.rem = 31'(trial - {1'b0, s.den});
      r.dvd = {s.dvd[62:0], 1'b1};
    end else begin
      r.rem = trial[30:0];
      r.dvd = {s.dvd[62:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[rtl/ptc_front.sv]
// ----------------------------------------------------------------------------
// ptc_front
// Temperature compensation and pressure coefficient stages, nine registers
// deep, ending in the signed magnitudes for the divider.
// ----------------------------------------------------------------------------
module ptc_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  logic [19:0]    raw_t,
  input  logic [19:0]    raw_p,
  input  ptc_pkg::trim_t trim,
  output logic           out_v,
  output ptc_pkg::front_t out_d
);
  import ptc_pkg::*;

  logic               v1, v2, v3, v4, v5, v6, v7, v8;
  logic signed [17:0] x1;
  logic signed [16:0] dt;
  logic signed [33:0] pa_next, dd_next, pa, dd;
  logic [19:0]        rawp1, rawp2, rawp3, rawp4, rawp5, rawp6;
  logic               skip1, skip2, skip3, skip4, skip5, skip6, skip7, skip8;
  logic signed [22:0] ta_next, ta;
  logic signed [36:0] bq_next, bq;
  logic signed [23:0] fine_next, fine;
  logic signed [27:0] f5;
  logic signed [19:0] t20;
  logic [15:0]        temp_next, temp4, temp5, temp6, temp7, temp8;
  logic signed [24:0] a0;
  logic signed [49:0] sq_next, sq;
  logic signed [40:0] ap5_next, ap2_next, ap5, ap2, ap5_5, ap2_5;
  logic signed [65:0] b6w, p3w;
  logic [63:0]        b6, p3x, bb_next, aa_next, bb, aa;
  logic [63:0]        m_next, pn_next, m, pn;
  logic [20:0]        pr;
  logic [63:0]        num_next, num;
  logic [30:0]        dv;
  front_t             fd_next;

  // Stage 1: first temperature terms
  assign x1      = $signed({1'b0, raw_t[19:3]}) - $signed({1'b0, trim.t1, 1'b0});
  assign dt      = $signed({1'b0, raw_t[19:4]}) - $signed({1'b0, trim.t1});
  assign pa_next = x1 * $signed(trim.t2);
  assign dd_next = dt * dt;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_v;
    if (en) begin
      pa    <= pa_next;
      dd    <= dd_next;
      rawp1 <= raw_p;
      skip1 <= (raw_t == SKIP_MARK) || (raw_p == SKIP_MARK);
    end
  end

  // Stage 2: scale the linear term, weight the square by T3
  assign ta_next = $signed(pa[33:11]);
  assign bq_next = $signed({1'b0, dd[31:12]}) * $signed(trim.t3);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      ta    <= ta_next;
      bq    <= bq_next;
      rawp2 <= rawp1;
      skip2 <= skip1;
    end
  end

  // Stage 3: fine temperature
  assign fine_next = ta + $signed(bq[36:14]);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      fine  <= fine_next;
      rawp3 <= rawp2;
      skip3 <= skip2;
    end
  end

  // Stage 4: centidegrees with saturation, pressure offset products
  assign f5  = fine * $signed(28'd5) + $signed(28'd128);
  assign t20 = f5[27:8];
  always_comb begin
    if ((t20[19:15] == 5'b00000) || (t20[19:15] == 5'b11111)) begin
      temp_next = t20[15:0];
    end else if (t20[19]) begin
      temp_next = 16'h8000;
    end else begin
      temp_next = 16'h7FFF;
    end
  end
  assign a0       = fine - $signed(FINE_BIAS);
  assign sq_next  = a0 * a0;
  assign ap5_next = a0 * $signed(trim.p5);
  assign ap2_next = a0 * $signed(trim.p2);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      temp4 <= temp_next;
      sq    <= sq_next;
      ap5   <= ap5_next;
      ap2   <= ap2_next;
      rawp4 <= rawp3;
      skip4 <= skip3;
    end
  end

  // Stage 5: square terms weighted by P6 and P3
  assign b6w = sq * $signed(trim.p6);
  assign p3w = sq * $signed(trim.p3);

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      b6    <= b6w[63:0];
      p3x   <= p3w[63:0];
      ap5_5 <= ap5;
      ap2_5 <= ap2;
      temp5 <= temp4;
      rawp5 <= rawp4;
      skip5 <= skip4;
    end
  end

  // Stage 6: sum the offset and the divisor polynomial
  assign bb_next = b6 + ({{23{ap5_5[40]}}, ap5_5} << 17)
                 + ({{48{trim.p4[15]}}, trim.p4} << 35);
  assign aa_next = {{8{p3x[63]}}, p3x[63:8]} + ({{23{ap2_5[40]}}, ap2_5} << 12);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      bb    <= bb_next;
      aa    <= aa_next;
      temp6 <= temp5;
      rawp6 <= rawp5;
      skip6 <= skip5;
    end
  end

  // Stage 7: divisor product, numerator before scaling
  assign m_next  = (P_OFFSET + aa) * {48'd0, trim.p1};
  assign pr      = P_FULL - {1'b0, rawp6};
  assign pn_next = {12'd0, pr, 31'd0} - bb;

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
    if (en) begin
      m     <= m_next;
      pn    <= pn_next;
      temp7 <= temp6;
      skip7 <= skip6;
    end
  end

  // Stage 8: scale numerator, take the divisor
  assign num_next = pn * P_SCALE;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= v7;
    if (en) begin
      num   <= num_next;
      dv    <= m[63:33];
      temp8 <= temp7;
      skip8 <= skip7;
    end
  end

  // Stage 9: magnitudes and quotient sign
  always_comb begin
    fd_next      = '0;
    fd_next.un   = num[63] ? (64'd0 - num) : num;
    fd_next.ud   = dv[30] ? (31'd0 - dv) : dv;
    fd_next.neg  = num[63] ^ dv[30];
    fd_next.zero = (dv == 31'd0);
    fd_next.skip = skip8;
    fd_next.temp = temp8;
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= v8;
    if (en) out_d <= fd_next;
  end

endmodule

[rtl/ptc_div.sv]
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined restoring divider: one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_v,
  input  ptc_pkg::front_t in_d,
  output logic            out_v,
  output ptc_pkg::div_t   out_d
);
  import ptc_pkg::*;

  logic vld [DIV_STAGES];
  div_t stg [DIV_STAGES];
  div_t seed;

  // Load the dividend with a cleared partial remainder
  always_comb begin
    seed      = '0;
    seed.dvd  = in_d.un;
    seed.den  = in_d.ud;
    seed.neg  = in_d.neg;
    seed.zero = in_d.zero;
    seed.skip = in_d.skip;
    seed.temp = in_d.temp;
  end

  // Advance every stage together
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) vld[i] <= 1'b0;
        else if (en) vld[i] <= in_v;
        if (en) stg[i] <= div_step(seed);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) vld[i] <= 1'b0;
        else if (en) vld[i] <= vld[i-1];
        if (en) stg[i] <= div_step(stg[i-1]);
      end
    end
  end

  assign out_v = vld[DIV_STAGES-1];
  assign out_d = stg[DIV_STAGES-1];

endmodule

[rtl/ptc_back.sv]
// ----------------------------------------------------------------------------
// ptc_back
// Quadratic pressure correction, offset, saturation and result packing,
// six register stages.
// ----------------------------------------------------------------------------
module ptc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  ptc_pkg::div_t    in_d,
  input  ptc_pkg::trim_t   trim,
  output logic             out_v,
  output ptc_pkg::result_t out_d
);
  import ptc_pkg::*;

  logic        v1, v2, v3, v4, v5;
  logic [63:0] q1, q2, q3, q4;
  logic [15:0] temp1, temp2, temp3, temp4, temp5;
  logic        zero1, zero2, zero3, zero4, zero5;
  logic        skip1, skip2, skip3, skip4, skip5;
  logic [63:0] s;
  logic [63:0] pp0_next, pp0, b3_next, b3;
  logic [31:0] pp1_next, pp1;
  logic [63:0] ss, b3s, b3s4;
  logic [63:0] tt, a3;
  logic [63:0] sum;
  logic [63:0] ps;
  result_t     res_next;

  // Stage 1: restore the quotient sign
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_v;
    if (en) begin
      q1    <= in_d.neg ? (64'd0 - in_d.dvd) : in_d.dvd;
      temp1 <= in_d.temp;
      zero1 <= in_d.zero;
      skip1 <= in_d.skip;
    end
  end

  // Stage 2: partial products of the squared scaled pressure, P8 term
  assign s        = {{13{q1[63]}}, q1[63:13]};
  assign pp0_next = s[31:0] * s[31:0];
  assign pp1_next = s[63:32] * s[31:0];
  assign b3_next  = q1 * {{48{trim.p8[15]}}, trim.p8};

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      pp0   <= pp0_next;
      pp1   <= pp1_next;
      b3    <= b3_next;
      q2    <= q1;
      temp2 <= temp1;
      zero2 <= zero1;
      skip2 <= skip1;
    end
  end

  // Stage 3: combine partial products
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      ss    <= pp0 + {pp1[30:0], 33'd0};
      b3s   <= {{19{b3[63]}}, b3[63:19]};
      q3    <= q2;
      temp3 <= temp2;
      zero3 <= zero2;
      skip3 <= skip2;
    end
  end

  // Stage 4: weight the square by P9
  assign tt = ss * {{48{trim.p9[15]}}, trim.p9};

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      a3    <= {{25{tt[63]}}, tt[63:25]};
      b3s4  <= b3s;
      q4    <= q3;
      temp4 <= temp3;
      zero4 <= zero3;
      skip4 <= skip3;
    end
  end

  // Stage 5: sum the corrections
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      sum   <= q4 + a3 + b3s4;
      temp5 <= temp4;
      zero5 <= zero4;
      skip5 <= skip4;
    end
  end

  // Stage 6: offset, saturate, pack the result
  assign ps = {{8{sum[63]}}, sum[63:8]} + ({{48{trim.p7[15]}}, trim.p7} << 4);

  always_comb begin
    res_next = '0;
    if (!skip5) begin
      res_next.temperature_centi = temp5;
      res_next.sample_ok         = 1'b1;
      if (!zero5) begin
        res_next.pressure_ok = 1'b1;
        if (ps[63]) begin
          res_next.pressure_q8 = '0;
        end else if (ps[62:25] != '0) begin
          res_next.pressure_q8 = PRESS_MAX;
        end else begin
          res_next.pressure_q8 = ps[24:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_v <= 1'b0;
    else if (en) out_v <= v5;
    if (en) out_d <= res_next;
  end

endmodule

[rtl/pressure_temperature_compensation.sv]
// Path from an accepted request to out_valid: 9 front stages, 64 divider
// stages, 6 back stages, then the output register.
// Throughput: one request per cycle while in_stall is low; the 64-stage divider
// retires one quotient bit per stage so every stage takes a new sample each cycle.
// Reset: rst clears all trim registers to zero and every valid bit.
// ----------------------------------------------------------------------------
// pressure_temperature_compensation
// Top level: configuration registers, compensation pipeline, output
// register with a one-entry skid buffer.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [19:0] raw_temperature,
  input  logic [19:0] raw_pressure,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] temperature_centi,
  output logic [24:0] pressure_q8,
  output logic        sample_ok,
  output logic        pressure_ok
);
  import ptc_pkg::*;

  logic [47:0] temp_trim;
  logic [63:0] press_trim_low, press_trim_mid;
  logic [15:0] press_trim_high;
  trim_t       trim;
  logic        en;
  logic        fr_v, dv_v, bk_v;
  front_t      fr_d;
  div_t        dv_d;
  result_t     bk_d, od, sd;
  logic        ov, sv;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_trim       <= '0;
      press_trim_low  <= '0;
      press_trim_mid  <= '0;
      press_trim_high <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_TRIM:  temp_trim       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_trim_low  <= cfg_data;
        REG_PRESS_MID:  press_trim_mid  <= cfg_data;
        REG_PRESS_HIGH: press_trim_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Split the trim words
  always_comb begin
    trim.t1 = temp_trim[15:0];
    trim.t2 = temp_trim[31:16];
    trim.t3 = temp_trim[47:32];
    trim.p1 = press_trim_low[15:0];
    trim.p2 = press_trim_low[31:16];
    trim.p3 = press_trim_low[47:32];
    trim.p4 = press_trim_low[63:48];
    trim.p5 = press_trim_mid[15:0];
    trim.p6 = press_trim_mid[31:16];
    trim.p7 = press_trim_mid[47:32];
    trim.p8 = press_trim_mid[63:48];
    trim.p9 = press_trim_high;
  end

  // Pipeline advances unless the skid entry is occupied
  assign en       = !sv;
  assign in_stall = sv;

  ptc_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (in_valid),
    .raw_t (raw_temperature),
    .raw_p (raw_pressure),
    .trim  (trim),
    .out_v (fr_v),
    .out_d (fr_d)
  );

  ptc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (fr_v),
    .in_d  (fr_d),
    .out_v (dv_v),
    .out_d (dv_d)
  );

  ptc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .in_v  (dv_v),
    .in_d  (dv_d),
    .trim  (trim),
    .out_v (bk_v),
    .out_d (bk_d)
  );

  // Output register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (sv) begin
      if (!ov || !out_stall) begin
        od <= sd;
        ov <= 1'b1;
        sv <= 1'b0;
      end
    end else if (bk_v) begin
      if (!ov || !out_stall) begin
        od <= bk_d;
        ov <= 1'b1;
      end else begin
        sd <= bk_d;
        sv <= 1'b1;
      end
    end else if (!out_stall) begin
      ov <= 1'b0;
    end
  end

  assign out_valid         = ov;
  assign temperature_centi = od.temperature_centi;
  assign pressure_q8       = od.pressure_q8;
  assign sample_ok         = od.sample_ok;
  assign pressure_ok       = od.pressure_ok;

endmodule

[rtl/ptc_checker.sv]
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic signed [15:0] temperature_centi,
  input logic [24:0] pressure_q8,
  input logic        sample_ok,
  input logic        pressure_ok
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Zero every field of a skipped sample
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_ok |-> (temperature_centi == 16'sd0) &&
                                (pressure_q8 == 25'd0) && !pressure_ok)
    else $error("skipped sample carries data");

  // Force pressure to zero when flagged bad
  a_press_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pressure_ok |-> pressure_q8 == 25'd0)
    else $error("bad pressure not cleared");

  // Back-pressure the input only after the output stalls
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without output stall");

endmodule

bind pressure_temperature_compensation ptc_checker u_chk (.*);

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw temperature and pressure requests through the compensation
// pipeline under several trim settings, predicts every result with an
// integer model of the trimming scheme and checks each field in order.
// ----------------------------------------------------------------------------
module testbench;
  import ptc_pkg::*;

  localparam int N_RANDOM = 1600;

  // Holds the trim copy, predicts results and compares them in order
  class comp_scoreboard;
    logic [63:0] temp_trim;
    logic [63:0] press_low;
    logic [63:0] press_mid;
    logic [63:0] press_high;
    result_t     pending[$];
    int          errors;

    function new();
      temp_trim  = '0;
      press_low  = '0;
      press_mid  = '0;
      press_high = '0;
      errors     = 0;
    endfunction

    function logic [63:0] sx(logic [15:0] v);
      return {{48{v[15]}}, v};
    endfunction

    function logic [63:0] asr(logic [63:0] x, int n);
      return 64'($signed(x) >>> n);
    endfunction

    // Signed divide truncating toward zero
    function logic [63:0] sdiv(logic [63:0] num, logic [63:0] den);
      logic [63:0] un, ud, q;
      un = num[63] ? 64'd0 - num : num;
      ud = den[63] ? 64'd0 - den : den;
      q  = un / ud;
      return (num[63] != den[63]) ? 64'd0 - q : q;
    endfunction

    function result_t compensate(logic [19:0] rt, logic [19:0] rp);
      logic [63:0] adt, adp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, d, fine, p;
      longint      tv, pv;
      result_t     r;
      r   = '0;
      adt = {44'd0, rt};
      adp = {44'd0, rp};
      t1  = {48'd0, temp_trim[15:0]};
      t2  = sx(temp_trim[31:16]);
      t3  = sx(temp_trim[47:32]);
      p1  = {48'd0, press_low[15:0]};
      p2  = sx(press_low[31:16]);
      p3  = sx(press_low[47:32]);
      p4  = sx(press_low[63:48]);
      p5  = sx(press_mid[15:0]);
      p6  = sx(press_mid[31:16]);
      p7  = sx(press_mid[47:32]);
      p8  = sx(press_mid[63:48]);
      p9  = sx(press_high[15:0]);
      if (rt == SKIP_MARK || rp == SKIP_MARK) return r;
      // temperature
      a    = asr(((adt >> 3) - (t1 << 1)) * t2, 11);
      d    = (adt >> 4) - t1;
      b    = asr(asr(d * d, 12) * t3, 14);
      fine = a + b;
      tv   = $signed(asr(fine * 64'd5 + 64'd128, 8));
      if (tv < -32768) tv = -32768;
      if (tv > 32767) tv = 32767;
      r.temperature_centi = tv[15:0];
      r.sample_ok = 1'b1;
      // pressure
      a = fine - 64'd128000;
      b = a * a * p6;
      b = b + ((a * p5) << 17);
      b = b + (p4 << 35);
      a = asr(a * a * p3, 8) + ((a * p2) << 12);
      a = asr(((64'd1 << 47) + a) * p1, 33);
      if (a == 64'd0) return r;
      p  = 64'd1048576 - adp;
      p  = sdiv(((p << 31) - b) * 64'd3125, a);
      a  = asr(p9 * asr(p, 13) * asr(p, 13), 25);
      b  = asr(p8 * p, 19);
      p  = asr(p + a + b, 8) + (p7 << 4);
      pv = $signed(p);
      if (pv < 0) pv = 0;
      if (pv > 33554431) pv = 33554431;
      r.pressure_q8 = pv[24:0];
      r.pressure_ok = 1'b1;
      return r;
    endfunction

    function void note_request(logic [19:0] rt, logic [19:0] rp);
      pending.push_back(compensate(rt, rp));
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(result_t got);
      result_t want;
      if (pending.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = pending.pop_front();
      if (got.temperature_centi != want.temperature_centi)
        report("temperature_centi", $signed(got.temperature_centi),
               $signed(want.temperature_centi));
      if (got.pressure_q8 != want.pressure_q8)
        report("pressure_q8", got.pressure_q8, want.pressure_q8);
      if (got.sample_ok != want.sample_ok)
        report("sample_ok", got.sample_ok, want.sample_ok);
      if (got.pressure_ok != want.pressure_ok)
        report("pressure_ok", got.pressure_ok, want.pressure_ok);
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  logic        out_valid;
  logic        out_stall;
  logic signed [15:0] temperature_centi;
  logic [24:0] pressure_q8;
  logic        sample_ok;
  logic        pressure_ok;
  logic        stall_quiet;

  comp_scoreboard sb = new();

  pressure_temperature_compensation dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
    .out_valid(out_valid), .out_stall(out_stall),
    .temperature_centi(temperature_centi), .pressure_q8(pressure_q8),
    .sample_ok(sample_ok), .pressure_ok(pressure_ok)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Note accepted requests and check accepted results
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) sb.note_request(raw_temperature, raw_pressure);
    if (!rst && out_valid && !out_stall)
      sb.check_result('{temperature_centi, pressure_q8, sample_ok, pressure_ok});
  end

  // Stall the result side: mostly short bursts, a few long, quiet stretches
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      if (stall_quiet || $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 40);
      end else begin
        out_stall <= 1'($urandom_range(0, 1));
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 4);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Hold one register write until accepted; the caller drops valid
  task write_reg(logic [1:0] idx, logic [63:0] value);
    logic ready_seen;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    forever begin
      @(negedge clk) ready_seen = cfg_ready;
      @(posedge clk);
      if (ready_seen) break;
    end
    case (idx)
      REG_TEMP_TRIM:  sb.temp_trim  = {16'd0, value[47:0]};
      REG_PRESS_LOW:  sb.press_low  = value;
      REG_PRESS_MID:  sb.press_mid  = value;
      REG_PRESS_HIGH: sb.press_high = {48'd0, value[15:0]};
      default: ;
    endcase
  endtask

  task load_trims(logic [47:0] tt, logic [63:0] pl, logic [63:0] pm, logic [15:0] ph);
    write_reg(REG_TEMP_TRIM, {$urandom, $urandom} & 64'hFFFF_0000_0000_0000 | tt);
    write_reg(REG_PRESS_LOW, pl);
    write_reg(REG_PRESS_MID, pm);
    write_reg(REG_PRESS_HIGH, {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_0000 | ph);
    cfg_valid <= 1'b0;
  endtask

  // Hold one request until accepted, then maybe idle
  task send_request(logic [19:0] rt, logic [19:0] rp);
    logic stall_seen;
    int   gap;
    in_valid        <= 1'b1;
    raw_temperature <= rt;
    raw_pressure    <= rp;
    forever begin
      @(negedge clk) stall_seen = in_stall;
      @(posedge clk);
      if (!stall_seen) break;
    end
    if ($urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function logic [19:0] pick_temp(bit full);
    if (full || $urandom_range(0, 3) == 0) return 20'($urandom);
    return 20'($urandom_range(380000, 620000));
  endfunction

  function logic [19:0] pick_press(bit full);
    if (full || $urandom_range(0, 3) == 0) return 20'($urandom);
    return 20'($urandom_range(250000, 600000));
  endfunction

  task random_requests(int count, bit full);
    logic [19:0] rt, rp;
    for (int i = 0; i < count; i++) begin
      rt = pick_temp(full);
      rp = pick_press(full);
      if ($urandom_range(0, 49) == 0) rt = SKIP_MARK;
      if ($urandom_range(0, 49) == 0) rp = SKIP_MARK;
      send_request(rt, rp);
    end
  endtask

  initial begin
    logic [47:0] tt_typ;
    logic [63:0] pl_typ, pm_typ;
    rst             = 1'b1;
    cfg_valid       = 1'b0;
    cfg_index       = REG_TEMP_TRIM;
    cfg_data        = '0;
    in_valid        = 1'b0;
    raw_temperature = '0;
    raw_pressure    = '0;
    stall_quiet     = 1'b0;
    tt_typ = {16'hFC18, 16'd26435, 16'd27504};
    pl_typ = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    pm_typ = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset trims: pressure divisor is zero
    send_request(20'd519888, 20'd415148);
    send_request(20'h00000, 20'h00000);
    send_request(20'hFFFFF, 20'hFFFFF);
    drain();

    // Typical trims with directed corners
    load_trims(tt_typ, pl_typ, pm_typ, 16'd6000);
    send_request(20'd519888, 20'd415148);
    send_request(SKIP_MARK, 20'd415148);
    send_request(20'd519888, SKIP_MARK);
    send_request(SKIP_MARK, SKIP_MARK);
    send_request(20'h00000, 20'h00000);
    send_request(20'hFFFFF, 20'hFFFFF);
    send_request(20'h00000, 20'hFFFFF);
    send_request(20'hFFFFF, 20'h00000);
    send_request(20'h7FFFF, 20'h80001);
    send_request(20'h80001, 20'h7FFFF);
    stall_quiet = 1'b1;
    random_requests(N_RANDOM / 4, 1'b0);
    stall_quiet = 1'b0;
    random_requests(N_RANDOM / 4, 1'b0);
    drain();

    // Extreme trims: all positive maxima
    load_trims({3{16'h7FFF}}, {{3{16'h7FFF}}, 16'hFFFF}, {4{16'h7FFF}}, 16'h7FFF);
    send_request(20'h00000, 20'h00000);
    send_request(20'hFFFFF, 20'hFFFFF);
    random_requests(N_RANDOM / 16, 1'b1);
    drain();

    // Extreme trims: negative minima, with T1 and P1 at their unsigned maxima
    load_trims({{2{16'h8000}}, 16'hFFFF}, {{3{16'h8000}}, 16'hFFFF},
               {4{16'h8000}}, 16'h8000);
    send_request(20'h00000, 20'hFFFFF);
    send_request(20'hFFFFF, 20'h00000);
    random_requests(N_RANDOM / 16, 1'b1);
    drain();

    // Random trims around typical values, and fully random trims
    for (int k = 0; k < 6; k++) begin
      if (k % 2 == 0)
        load_trims(tt_typ ^ 48'($urandom_range(0, 255)), pl_typ ^ 64'($urandom_range(0, 255)),
                   pm_typ ^ 64'($urandom_range(0, 255)), 16'($urandom_range(0, 12000)));
      else
        load_trims(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom));
      random_requests(N_RANDOM / 16, 1'(k % 2));
      drain();
    end

    // Back to zero trims
    load_trims('0, '0, '0, '0);
    random_requests(20, 1'b1);
    drain();

    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
